// ----- hw/rtl/sds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types, codes and lookup tables for the segment display shadow RAM.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam int NumRamBytes = 10;
	localparam int NumChars    = 66;
	localparam int NumSegCodes = NumChars + 1;
	localparam int MaxLamp     = 27;
	localparam int NumLamps    = MaxLamp + 1;

	localparam int CharIdxW = $clog2(NumSegCodes);
	localparam int LampIdxW = $clog2(NumLamps);
	localparam int ByteIdxW = $clog2(NumRamBytes);

	// item modes
	localparam logic [1:0] MODE_CHAR  = 2'd0;
	localparam logic [1:0] MODE_LAMP  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BAD_POS = 2'd1;
	localparam logic [1:0] STATUS_BAD_ID  = 2'd2;

	// digit position that is split over two RAM bytes
	localparam logic [3:0] SplitPos = 4'd2;

	typedef logic [7:0] byte_t;
	typedef byte_t [NumRamBytes-1:0] ram_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_code;
		logic [3:0] position;
		logic [4:0] indicator_id;
		logic       indicator_on;
	} item_t;

	// segment patterns by character-set position; last entry is blank
	localparam byte_t SegRom [NumSegCodes] = '{
		8'h00, 8'h10, 8'hEE, 8'h48, 8'hD6, 8'hDA, 8'h78, 8'hBA,
		8'hBE, 8'hC8, 8'hFE, 8'hFA, 8'hFC, 8'hFE, 8'hA6, 8'hEE,
		8'hB6, 8'hB4, 8'hBE, 8'h7C, 8'h48, 8'h4A, 8'h7C, 8'h26,
		8'hEC, 8'hEC, 8'hEE, 8'hF4, 8'hEE, 8'hFC, 8'hBA, 8'hC8,
		8'h6E, 8'h6E, 8'h6E, 8'h6C, 8'h78, 8'h82, 8'h02, 8'h1E,
		8'h3E, 8'h16, 8'h5E, 8'hF6, 8'hB4, 8'hFA, 8'h3C, 8'h08,
		8'h0A, 8'h2C, 8'h26, 8'h1C, 8'h1C, 8'h1E, 8'hF4, 8'hF8,
		8'h14, 8'hBA, 8'h36, 8'h0E, 8'h0E, 8'h0E, 8'h0C, 8'h78,
		8'h12, 8'h10, 8'h00
	};

	// indicator map: high nibble is the RAM byte, low three bits the bit number
	localparam byte_t LampRom [NumLamps] = '{
		8'h17, 8'h16, 8'h37, 8'h27, 8'h57, 8'h47, 8'h77, 8'h76,
		8'h75, 8'h74, 8'h73, 8'h72, 8'h71, 8'h70, 8'h97, 8'h96,
		8'h95, 8'h94, 8'h93, 8'h92, 8'h91, 8'h90, 8'h87, 8'h86,
		8'h85, 8'h84, 8'h83, 8'h82
	};

	// position in the character set; blank entry when the code is not in it
	function automatic logic [CharIdxW-1:0] char_index(input logic [7:0] c);
		logic [CharIdxW-1:0] idx;
		idx = CharIdxW'(NumChars);
		if (c == 8'h20) begin
			idx = CharIdxW'(0);
		end else if (c == 8'h2D) begin
			idx = CharIdxW'(1);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			idx = CharIdxW'(c - 8'h30) + CharIdxW'(2);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			idx = CharIdxW'(c - 8'h41) + CharIdxW'(12);
		end else if (c == 8'h5F) begin
			idx = CharIdxW'(38);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			idx = CharIdxW'(c - 8'h61) + CharIdxW'(39);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/segment_display_shadow_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segment_display_shadow_ram
// Front-panel display RAM: character, indicator, clear and read requests.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    mode, char_code, position, indicator_id,
//                                  indicator_on
//  out      out_valid / out_ready  status, indicator_state, ram_byte_0..9
//
//  Each item is held in the input stage, then its result lands in the
//  output register; one item per clock while no result is held.
//  The RAM bytes update when an item leaves the input stage.
//  A held result stalls the input stage; in_ready drops only then.
//  Reset clears the RAM and both valid flags.
// ----------------------------------------------------------------------------
module segment_display_shadow_ram (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] char_code,
	input  wire logic [3:0] position,
	input  wire logic [4:0] indicator_id,
	input  wire logic       indicator_on,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic            indicator_state,
	output logic [7:0]      ram_byte_0,
	output logic [7:0]      ram_byte_1,
	output logic [7:0]      ram_byte_2,
	output logic [7:0]      ram_byte_3,
	output logic [7:0]      ram_byte_4,
	output logic [7:0]      ram_byte_5,
	output logic [7:0]      ram_byte_6,
	output logic [7:0]      ram_byte_7,
	output logic [7:0]      ram_byte_8,
	output logic [7:0]      ram_byte_9
);
	import sds_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	logic [7:0] seg;
	ram_t       ram_nxt;
	logic [1:0] status_c;
	logic       ind_c;

	logic       out_valid_q;
	logic [1:0] status_q;
	logic       ind_q;
	ram_t       ram_out_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{mode: mode, char_code: char_code, position: position,
				indicator_id: indicator_id, indicator_on: indicator_on};
		end
	end

	sds_char_enc u_char_enc (
		.char_code (item_s1.char_code),
		.seg       (seg)
	);

	sds_disp_ram u_disp_ram (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (advance),
		.item      (item_s1),
		.seg       (seg),
		.ram_nxt   (ram_nxt),
		.status    (status_c),
		.ind_state (ind_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_c;
			ind_q     <= ind_c;
			ram_out_q <= ram_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign indicator_state = ind_q;
	assign ram_byte_0      = ram_out_q[0];
	assign ram_byte_1      = ram_out_q[1];
	assign ram_byte_2      = ram_out_q[2];
	assign ram_byte_3      = ram_out_q[3];
	assign ram_byte_4      = ram_out_q[4];
	assign ram_byte_5      = ram_out_q[5];
	assign ram_byte_6      = ram_out_q[6];
	assign ram_byte_7      = ram_out_q[7];
	assign ram_byte_8      = ram_out_q[8];
	assign ram_byte_9      = ram_out_q[9];

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.mode == MODE_CLEAR |=> ram_out_q == '0)
		else $error("clear item did not give an all-zero display");

	a_bad_id_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == STATUS_BAD_ID |-> !ind_q)
		else $error("invalid indicator id reported as lit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a held result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> status_q == STATUS_OK || status_q == STATUS_BAD_POS
			|| status_q == STATUS_BAD_ID)
		else $error("status code out of range");

endmodule
`default_nettype wire

// ----- hw/rtl/sds_char_enc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sds_char_enc
// Character code to seven-segment pattern, through the character set and ROM.
// ----------------------------------------------------------------------------
module sds_char_enc (
	input  wire logic [7:0] char_code,
	output logic      [7:0] seg
);
	import sds_pkg::*;

	logic [CharIdxW-1:0] idx;

	always_comb begin
		idx = char_index(char_code);
		seg = SegRom[idx];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sds_disp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sds_disp_ram
// Ten display RAM bytes with the per-item read-modify-write and indicator read.
// ----------------------------------------------------------------------------
module sds_disp_ram (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           upd_en,
	input  wire sds_pkg::item_t item,
	input  wire logic [7:0]     seg,
	output sds_pkg::ram_t       ram_nxt,
	output logic [1:0]          status,
	output logic                ind_state
);
	import sds_pkg::*;

	ram_t                ram_q;
	logic                pos_ok;
	logic                id_ok;
	logic [LampIdxW-1:0] lamp_idx;
	byte_t               lamp_ent;
	logic [3:0]          lamp_byte;
	logic [2:0]          lamp_bit;
	logic [3:0]          digit_byte;

	always_comb begin
		pos_ok     = (item.position >= 4'd1) && (item.position <= 4'd7);
		id_ok      = item.indicator_id <= 5'(MaxLamp);
		lamp_idx   = id_ok ? LampIdxW'(item.indicator_id) : '0;
		lamp_ent   = LampRom[lamp_idx];
		lamp_byte  = lamp_ent[7:4];
		lamp_bit   = lamp_ent[2:0];
		digit_byte = item.position - 4'd1;
	end

	always_comb begin
		for (int i = 0; i < NumRamBytes; i++) begin
			ram_nxt[i] = ram_q[i];
			unique case (item.mode)
				MODE_CHAR: begin
					if (pos_ok) begin
						if (item.position == SplitPos) begin
							if (i == 1) ram_nxt[i] = {ram_q[i][7:6], seg[7:2]};
							if (i == 0) ram_nxt[i] = {seg[1], ram_q[i][6:0]};
						end else if (digit_byte == 4'(i)) begin
							ram_nxt[i] = {ram_q[i][7], seg[7:1]};
						end
					end
				end
				MODE_LAMP: begin
					if (id_ok && lamp_byte == 4'(i)) begin
						ram_nxt[i][lamp_bit] = item.indicator_on;
					end
				end
				MODE_CLEAR: begin
					ram_nxt[i] = '0;
				end
				MODE_READ: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (item.mode)
			MODE_CHAR:  status = pos_ok ? STATUS_OK : STATUS_BAD_POS;
			MODE_LAMP:  status = id_ok ? STATUS_OK : STATUS_BAD_ID;
			MODE_CLEAR: status = STATUS_OK;
			MODE_READ:  status = id_ok ? STATUS_OK : STATUS_BAD_ID;
			default:    status = STATUS_OK;
		endcase
		// indicator as it stands after this item
		ind_state = id_ok & ram_nxt[lamp_byte[ByteIdxW-1:0]][lamp_bit];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_q <= '0;
		end else if (upd_en) begin
			ram_q <= ram_nxt;
		end
	end

endmodule
`default_nettype wire
